// ===== rtl/core/tcem_pkg.sv =====
// Package for the time cluster event merger: sizes, reset values and the
// controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps
package tcem_pkg;

    localparam int MAX_EVENTS_DEF = 64;

    localparam int TIME_W   = 32;
    localparam int CONF_W   = 17;
    localparam int SRC_W    = 2;
    localparam int WGT_W    = 18;
    localparam int ENTRY_W  = TIME_W + CONF_W + 1 + SRC_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    // combined weight: (weight * conf) >> 16
    localparam int CW_W     = WGT_W + CONF_W - 16;
    localparam int PROD_W   = TIME_W + CW_W;

    localparam logic [CFG_IDX_W-1:0] REG_MERGE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BONUS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_PELVIS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_VELOC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_SALIENT = 3'd4;

    localparam logic [SRC_W-1:0] SRC_PELVIS    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_VELOCITY  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_SALIENCY  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_COMPOSITE = 2'd3;

    localparam logic [TIME_W-1:0] MERGE_THR_RST = 32'd3277;
    localparam logic [CONF_W-1:0] BONUS_RST     = 17'd6554;
    localparam logic [WGT_W-1:0]  WEIGHT_RST    = 18'd65536;
    localparam logic [CONF_W-1:0] ONE_Q16       = 17'd65536;
    localparam int                SMALL_WEIGHT  = 6;

    typedef struct packed {
        logic capture;     // latch incoming event, j = count
        logic rd_prev;     // read entry j-1
        logic wr_shift;    // move read entry up to j, j--
        logic wr_key;      // write new event at j, count++
        logic rd_walk;     // read entry i
        logic walk_init;   // i = 0, clear cluster sums
        logic dat;         // latch walked event, combined weight
        logic mul;         // time * combined weight
        logic acc;         // add event into the open cluster, i++
        logic div_start;   // load divider and finish side fields
        logic div_step;    // one quotient bit
        logic acc_clear;   // cluster transferred, clear sums
        logic count_clear; // set merged, empty the store
        logic fin;         // cluster is the final one of the set
    } tcem_cmd_t;

    typedef struct packed {
        logic full;
        logic j_zero;
        logic shift_gt;
        logic walk_end;
        logic joins;
        logic single;
        logic div_done;
        logic last_flag;
    } tcem_stat_t;

endpackage

// ===== rtl/core/tcem_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tcem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/tcem_ctrl.sv =====
// Controller state machine for the event merger: insertion, cluster walk,
// divide and result transfer. Depends on tcem_pkg.
`timescale 1ns / 1ps
module tcem_ctrl import tcem_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_last_event,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_last_result,
    input  tcem_stat_t stat,
    output tcem_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_INS_CHK    = 4'd1;
    localparam logic [3:0] S_INS_CMP    = 4'd2;
    localparam logic [3:0] S_WALK_START = 4'd3;
    localparam logic [3:0] S_WALK_RD    = 4'd4;
    localparam logic [3:0] S_WALK_DAT   = 4'd5;
    localparam logic [3:0] S_MUL        = 4'd6;
    localparam logic [3:0] S_ACC        = 4'd7;
    localparam logic [3:0] S_DIV_START  = 4'd8;
    localparam logic [3:0] S_DIV        = 4'd9;
    localparam logic [3:0] S_OUT        = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       fin_reg, fin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (!stat.full) begin
                        state_next = S_INS_CHK;
                    end else if (s_last_event) begin
                        state_next = S_WALK_START;
                    end
                end
            end
            S_INS_CHK: begin
                if (stat.j_zero) begin
                    cmd.wr_key = 1'b1;
                    state_next = stat.last_flag ? S_WALK_START : S_IDLE;
                end else begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (stat.shift_gt) begin
                    cmd.wr_shift = 1'b1;
                    state_next   = S_INS_CHK;
                end else begin
                    cmd.wr_key = 1'b1;
                    state_next = stat.last_flag ? S_WALK_START : S_IDLE;
                end
            end
            S_WALK_START: begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (stat.walk_end) begin
                    fin_next   = 1'b1;
                    state_next = S_DIV_START;
                end else begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_WALK_DAT;
                end
            end
            S_WALK_DAT: begin
                cmd.dat = 1'b1;
                if (stat.joins) begin
                    state_next = S_MUL;
                end else begin
                    fin_next   = 1'b0;
                    state_next = S_DIV_START;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_WALK_RD;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = stat.single ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (fin_reg) begin
                        cmd.count_clear = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        cmd.acc_clear = 1'b1;
                        state_next    = S_MUL;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.fin = fin_reg;
    end

    assign m_last_result = fin_reg;
endmodule

// ===== rtl/core/tcem_dp.sv =====
// Datapath for the event merger: config registers, event store, cluster
// sums, restoring divider and result registers. Depends on tcem_pkg, tcem_ram.
`timescale 1ns / 1ps
module tcem_dp import tcem_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [TIME_W-1:0]     s_event_time,
    input  logic [CONF_W-1:0]     s_event_confidence,
    input  logic                  s_event_contact,
    input  logic [SRC_W-1:0]      s_event_source,
    input  logic                  s_last_event,
    output logic [TIME_W-1:0]     m_merged_time,
    output logic [CONF_W-1:0]     m_merged_confidence,
    output logic                  m_merged_contact,
    output logic [SRC_W-1:0]      m_merged_source,
    input  tcem_cmd_t             cmd,
    output tcem_stat_t            stat
);
    localparam int AW   = $clog2(MAX_EVENTS);
    localparam int NW   = $clog2(MAX_EVENTS + 1);
    localparam int TWW  = PROD_W + NW;          // sum of time * weight
    localparam int TSW  = TIME_W + NW;          // sum of times
    localparam int WSW  = CW_W + NW;            // sum of weights
    localparam int DCW  = $clog2(TWW + 1);
    localparam int CFW  = CONF_W + CONF_W + NW; // confidence before saturation

    // configuration
    logic [TIME_W-1:0] thr_reg;
    logic [CONF_W-1:0] bonus_reg;
    logic [WGT_W-1:0]  w_pel_reg, w_vel_reg, w_sal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= MERGE_THR_RST;
            bonus_reg <= BONUS_RST;
            w_pel_reg <= WEIGHT_RST;
            w_vel_reg <= WEIGHT_RST;
            w_sal_reg <= WEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MERGE_THR: thr_reg   <= cfg_data;
                REG_BONUS:     bonus_reg <= cfg_data[CONF_W-1:0];
                REG_W_PELVIS:  w_pel_reg <= cfg_data[WGT_W-1:0];
                REG_W_VELOC:   w_vel_reg <= cfg_data[WGT_W-1:0];
                REG_W_SALIENT: w_sal_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // insertion control
    logic [NW-1:0]      count_reg, j_reg, i_reg;
    logic [ENTRY_W-1:0] key_reg;
    logic               last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                last_reg <= s_last_event;
            end
            if (cmd.wr_key) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.count_clear) begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg <= {s_event_time, s_event_confidence, s_event_contact, s_event_source};
            j_reg   <= count_reg;
        end else if (cmd.wr_shift) begin
            j_reg <= j_reg - 1'b1;
        end
        if (cmd.walk_init) begin
            i_reg <= '0;
        end else if (cmd.acc) begin
            i_reg <= i_reg + 1'b1;
        end
    end

    // event store
    logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [NW-1:0]      j_prev;

    assign j_prev    = j_reg - 1'b1;
    assign ram_raddr = cmd.rd_prev ? j_prev[AW-1:0] : i_reg[AW-1:0];
    assign ram_wdata = cmd.wr_shift ? ram_rdata : key_reg;

    tcem_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_EVENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_shift | cmd.wr_key),
        .waddr (j_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.rd_prev | cmd.rd_walk),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [TIME_W-1:0] rd_time, key_time;
    assign rd_time  = ram_rdata[ENTRY_W-1 -: TIME_W];
    assign key_time = key_reg[ENTRY_W-1 -: TIME_W];

    // walked event and combined weight
    logic [ENTRY_W-1:0] ev_reg;
    logic [CW_W-1:0]    cw_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WGT_W-1:0]   rd_weight;
    logic [WGT_W+CONF_W-1:0] wc_full;

    always_comb begin
        case (ram_rdata[SRC_W-1:0])
            SRC_PELVIS:   rd_weight = w_pel_reg;
            SRC_VELOCITY: rd_weight = w_vel_reg;
            SRC_SALIENCY: rd_weight = w_sal_reg;
            default:      rd_weight = WGT_W'(ONE_Q16);
        endcase
    end

    assign wc_full = rd_weight * ram_rdata[SRC_W+1 +: CONF_W];

    always_ff @(posedge aclk) begin
        if (cmd.dat) begin
            ev_reg <= ram_rdata;
            cw_reg <= wc_full[WGT_W+CONF_W-1:16];
        end
        if (cmd.mul) begin
            prod_reg <= ev_reg[ENTRY_W-1 -: TIME_W] * cw_reg;
        end
    end

    logic [TIME_W-1:0] ev_time;
    logic [CONF_W-1:0] ev_conf;
    assign ev_time = ev_reg[ENTRY_W-1 -: TIME_W];
    assign ev_conf = ev_reg[SRC_W+1 +: CONF_W];

    // open cluster sums
    logic [NW-1:0]      n_reg, vote_reg;
    logic [TWW-1:0]     tw_reg;
    logic [TSW-1:0]     ts_reg;
    logic [WSW-1:0]     ws_reg;
    logic [CONF_W-1:0]  maxc_reg;
    logic [ENTRY_W-1:0] first_reg;

    always_ff @(posedge aclk) begin
        if (cmd.walk_init || cmd.acc_clear) begin
            n_reg    <= '0;
            vote_reg <= '0;
            tw_reg   <= '0;
            ts_reg   <= '0;
            ws_reg   <= '0;
            maxc_reg <= '0;
        end else if (cmd.acc) begin
            n_reg    <= n_reg + 1'b1;
            vote_reg <= vote_reg + NW'(ev_reg[SRC_W]);
            tw_reg   <= tw_reg + TWW'(prod_reg);
            ts_reg   <= ts_reg + TSW'(ev_time);
            ws_reg   <= ws_reg + WSW'(cw_reg);
            if (ev_conf > maxc_reg) begin
                maxc_reg <= ev_conf;
            end
            if (n_reg == '0) begin
                first_reg <= ev_reg;
            end
        end
    end

    logic [TIME_W-1:0] start_time, gap_time;
    assign start_time = first_reg[ENTRY_W-1 -: TIME_W];
    assign gap_time   = rd_time - start_time;

    // restoring divider, one quotient bit per cycle
    logic [TWW-1:0] quo_reg;
    logic [WSW-1:0] rem_reg, dvs_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [WSW:0]   rem_sh;
    logic           take;

    assign rem_sh = {rem_reg, quo_reg[TWW-1]};
    assign take   = rem_sh >= {1'b0, dvs_reg};

    // merged side fields
    logic [CFW-1:0]    conf_sum;
    logic [CONF_W-1:0] conf_reg;
    logic              contact_reg, single_reg;

    assign conf_sum = CFW'(maxc_reg) + CFW'(bonus_reg) * CFW'(n_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            single_reg  <= (n_reg == NW'(1));
            rem_reg     <= '0;
            dcnt_reg    <= DCW'(TWW);
            conf_reg    <= (conf_sum > CFW'(ONE_Q16)) ? ONE_Q16 : conf_sum[CONF_W-1:0];
            contact_reg <= ({vote_reg, 1'b0} >= {1'b0, n_reg});
            if (ws_reg > WSW'(SMALL_WEIGHT)) begin
                quo_reg <= tw_reg;
                dvs_reg <= ws_reg;
            end else begin
                quo_reg <= TWW'(ts_reg);
                dvs_reg <= WSW'(n_reg);
            end
        end else if (cmd.div_step) begin
            rem_reg  <= take ? WSW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[WSW-1:0];
            quo_reg  <= {quo_reg[TWW-2:0], take};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // result fields
    assign m_merged_time       = single_reg ? start_time : quo_reg[TIME_W-1:0];
    assign m_merged_confidence = single_reg ? first_reg[SRC_W+1 +: CONF_W] : conf_reg;
    assign m_merged_contact    = single_reg ? first_reg[SRC_W] : contact_reg;
    assign m_merged_source     = single_reg ? first_reg[SRC_W-1:0] : SRC_COMPOSITE;

    // status
    always_comb begin
        stat           = '0;
        stat.full      = (count_reg == NW'(MAX_EVENTS));
        stat.j_zero    = (j_reg == '0);
        stat.shift_gt  = (rd_time > key_time);
        stat.walk_end  = (i_reg == count_reg);
        stat.joins     = (n_reg == '0) || (gap_time <= thr_reg);
        stat.single    = (n_reg == NW'(1));
        stat.div_done  = (dcnt_reg == '0);
        stat.last_flag = last_reg;
    end
endmodule

// ===== rtl/core/time_cluster_event_merger.sv =====
// Top level of the time cluster event merger: joins controller and datapath.
// Depends on tcem_pkg, tcem_ctrl, tcem_dp.
//
//  channel | ports                          | direction | handshake
//  --------+--------------------------------+-----------+------------------
//  events  | s_event_*, s_last_event        | in        | s_valid/s_ready
//  results | m_merged_*, m_last_result      | out       | m_valid/m_ready
//  config  | cfg_index, cfg_data            | in        | cfg_wr_en
//
// An event is sorted into the store on arrival, one store read per compare.
// The event marked last then starts the walk: per event a read, a latch,
// a multiply and an accumulate step, plus per cluster of two or more a
// bit-serial divide (one quotient bit a cycle).
// Reset is synchronous, active low, and empties the store at once.
// Input is not taken during a walk; a stalled result holds the walk.
`timescale 1ns / 1ps
module time_cluster_event_merger import tcem_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_event_time,
    input  logic [CONF_W-1:0]     s_event_confidence,
    input  logic                  s_event_contact,
    input  logic [SRC_W-1:0]      s_event_source,
    input  logic                  s_last_event,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TIME_W-1:0]     m_merged_time,
    output logic [CONF_W-1:0]     m_merged_confidence,
    output logic                  m_merged_contact,
    output logic [SRC_W-1:0]      m_merged_source,
    output logic                  m_last_result
);
    tcem_cmd_t  cmd;
    tcem_stat_t stat;

    tcem_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last_event  (s_last_event),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_last_result (m_last_result),
        .stat          (stat),
        .cmd           (cmd)
    );

    tcem_dp #(
        .MAX_EVENTS(MAX_EVENTS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_event_time        (s_event_time),
        .s_event_confidence  (s_event_confidence),
        .s_event_contact     (s_event_contact),
        .s_event_source      (s_event_source),
        .s_last_event        (s_last_event),
        .m_merged_time       (m_merged_time),
        .m_merged_confidence (m_merged_confidence),
        .m_merged_contact    (m_merged_contact),
        .m_merged_source     (m_merged_source),
        .cmd                 (cmd),
        .stat                (stat)
    );
endmodule

// ===== sim/time_cluster_event_merger_test.sv =====
// Self-checking testbench for the time cluster event merger: drives event sets
// over valid/ready, predicts cluster results, checks every result transfer.
// Depends on tcem_pkg and time_cluster_event_merger.
`timescale 1ns / 1ps
module time_cluster_event_merger_test;
    import tcem_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [TIME_W-1:0] tm;
        logic [CONF_W-1:0] conf;
        logic              contact;
        logic [SRC_W-1:0]  src;
        logic              last;
    } event_t;

    typedef struct {
        logic [TIME_W-1:0] tm;
        logic [CONF_W-1:0] conf;
        logic              contact;
        logic [SRC_W-1:0]  src;
        logic              last;
    } cluster_t;

    // directed row: event plus optional hand-typed result for single clusters
    typedef struct {
        event_t   ev;
        logic     typed;
        cluster_t res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MERGE_THR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [TIME_W-1:0] s_event_time = '0;
    logic [CONF_W-1:0] s_event_confidence = '0;
    logic s_event_contact = 1'b0;
    logic [SRC_W-1:0] s_event_source = '0;
    logic s_last_event = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [TIME_W-1:0] m_merged_time;
    logic [CONF_W-1:0] m_merged_confidence;
    logic m_merged_contact;
    logic [SRC_W-1:0] m_merged_source;
    logic m_last_result;

    time_cluster_event_merger dut (.*);

    always #1 aclk = ~aclk;

    // predictor state
    logic [TIME_W-1:0] thr_q;
    logic [CONF_W-1:0] bonus_q;
    logic [WGT_W-1:0]  wgt_q [3];
    event_t            held [$];
    cluster_t          expected_clusters [$];
    cluster_t          typed_results [$];

    int mismatches = 0;
    int transfers_in = 0;
    int transfers_out = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    function automatic logic [63:0] weight_of(logic [SRC_W-1:0] s);
        case (s)
            SRC_PELVIS:   return 64'(wgt_q[0]);
            SRC_VELOCITY: return 64'(wgt_q[1]);
            SRC_SALIENCY: return 64'(wgt_q[2]);
            default:      return 64'(ONE_Q16);
        endcase
    endfunction

    function automatic cluster_t merge_cluster(event_t evs[$], int first, int n, logic fin);
        cluster_t c;
        logic [63:0] wsum, tw, tsum, cw, cf;
        logic [CONF_W-1:0] maxc;
        int nc, nl;
        wsum = 0; tw = 0; tsum = 0; maxc = 0; nc = 0; nl = 0;
        c.last = fin;
        if (n == 1) begin
            c.tm = evs[first].tm; c.conf = evs[first].conf;
            c.contact = evs[first].contact; c.src = evs[first].src;
            return c;
        end
        for (int k = first; k < first + n; k++) begin
            cw = (weight_of(evs[k].src) * 64'(evs[k].conf)) >> 16;
            tw += 64'(evs[k].tm) * cw;
            wsum += cw;
            tsum += 64'(evs[k].tm);
            if (evs[k].conf > maxc) maxc = evs[k].conf;
            if (evs[k].contact) nc++; else nl++;
        end
        c.tm = (wsum > SMALL_WEIGHT) ? 32'(tw / wsum) : 32'(tsum / n);
        cf = 64'(maxc) + 64'(bonus_q) * 64'(n - 1);
        c.conf = (cf > 64'(ONE_Q16)) ? ONE_Q16 : cf[CONF_W-1:0];
        c.contact = (nc >= nl);
        c.src = SRC_COMPOSITE;
        return c;
    endfunction

    // store one accepted event; on the last mark sort, cluster and queue results
    task automatic predict_event(event_t ev);
        event_t s[$];
        event_t key;
        int j, first;
        logic [TIME_W-1:0] start;
        if (held.size() < MAX_EVENTS_DEF) held.push_back(ev);
        if (!ev.last || held.size() == 0) return;
        s = held;
        for (int i = 1; i < s.size(); i++) begin
            key = s[i];
            j = i;
            while (j > 0 && s[j-1].tm > key.tm) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = key;
        end
        first = 0;
        start = s[0].tm;
        for (int i = 1; i <= s.size(); i++) begin
            if (i < s.size() && (s[i].tm - start) <= thr_q) continue;
            expected_clusters.push_back(merge_cluster(s, first, i - first, i == s.size()));
            if (i < s.size()) begin
                first = i;
                start = s[i].tm;
            end
        end
        held.delete();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MERGE_THR: thr_q = val;
            REG_BONUS:     bonus_q = val[CONF_W-1:0];
            REG_W_PELVIS:  wgt_q[0] = val[WGT_W-1:0];
            REG_W_VELOC:   wgt_q[1] = val[WGT_W-1:0];
            REG_W_SALIENT: wgt_q[2] = val[WGT_W-1:0];
            default: ;
        endcase
    endtask

    // offer one event and hold it until the transfer; valid stays up for a
    // back-to-back follower and is dropped by the idle wait or by drain
    task automatic send_event(event_t ev);
        int idle;
        idle = $urandom_range(0, 5);
        if (idle != 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_event_time <= ev.tm; s_event_confidence <= ev.conf;
        s_event_contact <= ev.contact; s_event_source <= ev.src;
        s_last_event <= ev.last;
        do @(posedge aclk); while (!s_ready);
        predict_event(ev);
        transfers_in++;
        @(negedge aclk);
    endtask

    task automatic drain;
        if (s_valid) s_valid <= 1'b0;
        while (expected_clusters.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic event_t rand_event(logic [TIME_W-1:0] base, logic last);
        event_t e;
        case ($urandom_range(0, 3))
            0: e.tm = $urandom;
            default: e.tm = base + $urandom_range(0, 6000);
        endcase
        case ($urandom_range(0, 7))
            0: e.conf = 0;
            1: e.conf = ONE_Q16;
            2: e.conf = $urandom_range(65537, 131071);
            default: e.conf = $urandom_range(0, 65536);
        endcase
        e.contact = $urandom_range(0, 1);
        e.src = $urandom_range(0, 3);
        e.last = last;
        return e;
    endfunction

    task automatic send_set(int n);
        logic [TIME_W-1:0] base;
        base = $urandom;
        for (int k = 0; k < n; k++) send_event(rand_event(base, k == n - 1));
    endtask

    // receiver: random wait before each result; hold_off forces a long stall
    initial begin
        int idle;
        @(negedge aclk);
        forever begin
            idle = $urandom_range(0, 5);
            if (idle != 0 || hold_off) begin
                m_ready <= 1'b0;
                repeat (idle) @(negedge aclk);
                while (hold_off) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid) && !hold_off);
            @(negedge aclk);
        end
    end

    // check every result transfer against the oldest prediction, or a single cluster against the next hand-typed result
    always @(posedge aclk) begin
        cluster_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            transfers_out++;
            if (expected_clusters.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result time=%h", m_merged_time);
            end else begin
                exp_c = expected_clusters.pop_front();
                if (typed_results.size() != 0 && exp_c.src != SRC_COMPOSITE)
                    exp_c = typed_results.pop_front();
                if (m_merged_time !== exp_c.tm || m_merged_confidence !== exp_c.conf ||
                    m_merged_contact !== exp_c.contact || m_merged_source !== exp_c.src ||
                    m_last_result !== exp_c.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp t=%h c=%h k=%b s=%0d l=%b got t=%h c=%h k=%b s=%0d l=%b",
                                 exp_c.tm, exp_c.conf, exp_c.contact, exp_c.src, exp_c.last,
                                 m_merged_time, m_merged_confidence, m_merged_contact,
                                 m_merged_source, m_last_result);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off)
            idle_cycles <= 0;
        else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    row_t rows [$];

    initial begin
        row_t r;
        thr_q = MERGE_THR_RST; bonus_q = BONUS_RST;
        wgt_q[0] = WEIGHT_RST; wgt_q[1] = WEIGHT_RST; wgt_q[2] = WEIGHT_RST;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: singletons with typed results, then merges and edge cases
        r.typed = 1'b1;
        r.ev = '{32'hFFFF_FFFF, ONE_Q16, 1'b1, SRC_PELVIS, 1'b1};
        r.res = '{32'hFFFF_FFFF, ONE_Q16, 1'b1, SRC_PELVIS, 1'b1}; rows.push_back(r);
        r.ev = '{32'h0, 17'd0, 1'b0, SRC_VELOCITY, 1'b1};
        r.res = '{32'h0, 17'd0, 1'b0, SRC_VELOCITY, 1'b1}; rows.push_back(r);
        r.ev = '{32'h1234_5678, 17'h1FFFF, 1'b1, SRC_SALIENCY, 1'b1};
        r.res = '{32'h1234_5678, 17'h1FFFF, 1'b1, SRC_SALIENCY, 1'b1}; rows.push_back(r);
        r.typed = 1'b0;
        // tie vote, near-zero weight, equal times, threshold boundary
        r.ev = '{32'd1000, 17'd3, 1'b1, SRC_COMPOSITE, 1'b0}; rows.push_back(r);
        r.ev = '{32'd1001, 17'd2, 1'b0, SRC_PELVIS, 1'b1}; rows.push_back(r);
        r.ev = '{32'd5000, 17'd40000, 1'b0, SRC_SALIENCY, 1'b0}; rows.push_back(r);
        r.ev = '{32'd5000, 17'd30000, 1'b1, SRC_VELOCITY, 1'b0}; rows.push_back(r);
        r.ev = '{32'd1723, 17'd65536, 1'b0, SRC_COMPOSITE, 1'b0}; rows.push_back(r);
        r.ev = '{32'd8277, 17'd100000, 1'b0, SRC_PELVIS, 1'b0}; rows.push_back(r);
        r.ev = '{32'd8278, 17'd500, 1'b1, SRC_SALIENCY, 1'b1}; rows.push_back(r);
        r.ev = '{32'h8000_0000, 17'd65535, 1'b1, SRC_COMPOSITE, 1'b0}; rows.push_back(r);
        r.ev = '{32'h7FFF_FFFF, 17'd1, 1'b0, SRC_VELOCITY, 1'b1}; rows.push_back(r);
        foreach (rows[k]) begin
            if (rows[k].typed) typed_results.push_back(rows[k].res);
            send_event(rows[k].ev);
        end
        drain();

        // extreme settings: zero weights, max threshold, big bonus
        write_reg(REG_MERGE_THR, 32'hFFFF_FFFF);
        write_reg(REG_BONUS, 32'd65536);
        write_reg(REG_W_PELVIS, 32'd0);
        write_reg(REG_W_VELOC, 32'd262143);
        write_reg(REG_W_SALIENT, 32'd0);
        for (int k = 0; k < 3; k++) send_set($urandom_range(2, 5));
        drain();

        // store overflow: 66 events, the last two dropped, the last mark still starting the merge
        write_reg(REG_MERGE_THR, 32'd0);
        write_reg(REG_BONUS, 32'd131071);
        for (int k = 0; k < 66; k++) send_event(rand_event(32'd0, k == 65));
        drain();

        // long receiver stall while sets keep coming, so the input backs up
        write_reg(REG_MERGE_THR, 32'd4000);
        write_reg(REG_BONUS, 32'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_set(20);
                send_set(6);
                s_valid <= 1'b0;
            end
        join
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_MERGE_THR, $urandom_range(0, 20000));
            write_reg(REG_BONUS, $urandom_range(0, 65536));
            write_reg(REG_W_PELVIS, $urandom_range(0, 262143));
            write_reg(REG_W_VELOC, $urandom_range(0, 262143));
            write_reg(REG_W_SALIENT, $urandom_range(0, 262143));
            for (int k = 0; k < 5; k++) send_set($urandom_range(1, 8));
            drain();
        end
        write_reg(REG_MERGE_THR, 32'd3277);
        write_reg(REG_BONUS, 32'd6554);
        write_reg(REG_W_PELVIS, 32'd65536);
        write_reg(REG_W_VELOC, 32'd65536);
        write_reg(REG_W_SALIENT, 32'd65536);
        for (int k = 0; k < 3; k++) send_set($urandom_range(1, 8));
        drain();

        $display("covered %0d event transfers and %0d cluster transfers over several settings",
                 transfers_in, transfers_out);
        if (mismatches == 0 && expected_clusters.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/tcem_pkg.sv
rtl/core/tcem_ram.sv
rtl/core/tcem_ctrl.sv
rtl/core/tcem_dp.sv
rtl/core/time_cluster_event_merger.sv
sim/time_cluster_event_merger_test.sv
